### hdl/float32_to_decimal96_assert.svh
// Assertion macros shared by the float32_to_decimal96 RTL.
`ifndef FLOAT32_TO_DECIMAL96_ASSERT_SVH
`define FLOAT32_TO_DECIMAL96_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define F2D_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define F2D_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/f2d_pkg.sv
// ----------------------------------------------------------------------------
// f2d_pkg
// Types and constants shared by the binary32 to decimal96 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package f2d_pkg;

    // Working magnitude, wide enough for the largest scaled value.
    localparam int NUM_W   = 144;
    localparam int COEFF_W = 96;
    // Rounded coefficient of the scaled path never exceeds 26 bits.
    localparam int RND_W   = 26;
    localparam int QUOT_W  = 23;

    typedef struct packed {
        logic [QUOT_W-1:0] quot;
        logic              rem_zero;
    } div10_t;

endpackage

`default_nettype wire

### hdl/float32_to_decimal96.sv
// NaN, infinity, zero, out-of-range and integer inputs go from ST_IDLE straight
// to ST_DONE. Other values pass ST_SCALE, with up to MAX_SCALE times-ten steps,
// then ST_ROUND and ST_EXTRACT, then ST_STRIP, which strips trailing zeros
// (skipped when the value rounds to zero). ST_DONE waits for the output register.
// One item is in work at a time, so a new item is taken only once the last
// result has left ST_DONE. Reset (synchronous, aresetn low) empties the block.
`default_nettype none

module float32_to_decimal96 #(
    parameter int MAX_SCALE = 28
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // [31:0] float_bits
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [31:0] coeff_low, [63:32] coeff_mid, [95:64] coeff_high,
    // [100:96] scale, [101] negative, [103:102] zero fill
    output logic [103:0]      m_tdata,
    output logic              m_tuser    // [0] error
);

    localparam int NW = f2d_pkg::NUM_W;
    localparam int CW = f2d_pkg::COEFF_W;
    localparam int RW = f2d_pkg::RND_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCALE   = 3'd1;
    localparam logic [2:0] ST_ROUND   = 3'd2;
    localparam logic [2:0] ST_EXTRACT = 3'd3;
    localparam logic [2:0] ST_STRIP   = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] mask_reg, mask_next;
    logic [NW-1:0] rbit_reg, rbit_next;
    logic [6:0]    sh_reg, sh_next;
    logic [4:0]    k_reg, k_next;
    logic [RW-1:0] r_reg, r_next;
    logic          sign_reg, sign_next;
    logic [CW-1:0] res_coeff_reg, res_coeff_next;
    logic [4:0]    res_scale_reg, res_scale_next;
    logic          res_neg_reg, res_neg_next;
    logic          res_err_reg, res_err_next;
    logic          m_valid_reg, m_valid_next;
    logic [103:0]  m_data_reg, m_data_next;
    logic          m_user_reg, m_user_next;

    logic          in_accept;
    logic [7:0]    bexp;
    logic [23:0]   man;
    logic [6:0]    sh_in;
    logic [7:0]    top_pos;
    logic [6:0]    big_sh;
    logic [NW-1:0] add_a, add_b, add_sum;
    logic          reached;
    logic [NW-1:0] shifted;
    logic [24:0]   r_raw;
    logic [24:0]   r_half;
    logic [RW-1:0] r_round;
    f2d_pkg::div10_t dv;

    f2d_div10 u_div10 (
        .value (r_reg),
        .res   (dv)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    assign bexp    = s_tdata[30:23];
    assign man     = {1'b1, s_tdata[22:0]};
    assign sh_in   = 7'(8'd150 - bexp);
    // Bit position of 2^21 in the integer part; can exceed 127.
    assign top_pos = {1'b0, sh_in} + 8'd21;
    assign big_sh  = 7'(bexp - 8'd150);

    // Shared adder: times ten as 8n + 2n while scaling, else the rounding bit.
    assign add_a   = (state_reg == ST_SCALE) ? (n_reg << 3) : n_reg;
    assign add_b   = (state_reg == ST_SCALE) ? (n_reg << 1) : rbit_reg;
    assign add_sum = add_a + add_b;
    assign reached = |(n_reg & mask_reg);

    // Round the integer part to 24 significant bits, ties to even.
    assign shifted = n_reg >> sh_reg;
    assign r_raw   = shifted[24:0];
    assign r_half  = {1'b0, r_raw[24:1]} + 25'(r_raw[0] & r_raw[1]);
    assign r_round = r_raw[24] ? {r_half, 1'b0} : {1'b0, r_raw};

    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        mask_next      = mask_reg;
        rbit_next      = rbit_reg;
        sh_next        = sh_reg;
        k_next         = k_reg;
        r_next         = r_reg;
        sign_next      = sign_reg;
        res_coeff_next = res_coeff_reg;
        res_scale_next = res_scale_reg;
        res_neg_next   = res_neg_reg;
        res_err_next   = res_err_reg;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        m_valid_next   = m_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    res_coeff_next = '0;
                    res_scale_next = '0;
                    res_neg_next   = 1'b0;
                    res_err_next   = 1'b0;
                    sign_next      = s_tdata[31];
                    state_next     = ST_DONE;
                    if (bexp == 8'hFF) begin
                        res_err_next = 1'b1;
                    end else if (s_tdata[30:0] == 31'd0 || bexp <= 8'd33 ||
                                 bexp >= 8'd223) begin
                        res_err_next = 1'b0;
                    end else if (bexp >= 8'd150) begin
                        res_coeff_next = CW'(man) << big_sh;
                        res_neg_next   = s_tdata[31];
                    end else begin
                        n_next     = NW'(man);
                        sh_next    = sh_in;
                        mask_next  = ~((NW'(1) << top_pos) - NW'(1));
                        rbit_next  = NW'(1) << (sh_in - 7'd1);
                        k_next     = '0;
                        state_next = ST_SCALE;
                    end
                end
            end
            ST_SCALE: begin
                if (k_reg < 5'(MAX_SCALE) && !reached) begin
                    n_next = add_sum;
                    k_next = k_reg + 5'd1;
                end else begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                n_next     = add_sum;
                state_next = ST_EXTRACT;
            end
            ST_EXTRACT: begin
                r_next = r_round;
                if (r_round == '0) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP: begin
                if (k_reg != 5'd0 && dv.rem_zero) begin
                    r_next = RW'(dv.quot);
                    k_next = k_reg - 5'd1;
                end else begin
                    res_coeff_next = CW'(r_reg);
                    res_scale_next = k_reg;
                    res_neg_next   = sign_reg;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, res_neg_reg, res_scale_reg, res_coeff_reg};
                    m_user_next  = res_err_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            k_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            k_reg       <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg         <= n_next;
        mask_reg      <= mask_next;
        rbit_reg      <= rbit_next;
        sh_reg        <= sh_next;
        r_reg         <= r_next;
        sign_reg      <= sign_next;
        res_coeff_reg <= res_coeff_next;
        res_scale_reg <= res_scale_next;
        res_neg_reg   <= res_neg_next;
        res_err_reg   <= res_err_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

`include "float32_to_decimal96_assert.svh"

    `F2D_ASSERT_NOW(a_err_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata[101:0] == '0, "error item carries a nonzero value")
    `F2D_ASSERT_NOW(a_scale_max, aclk, aresetn, m_tvalid, m_tdata[100:96] <= 5'(MAX_SCALE), "scale above limit")
    `F2D_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "accepted a second item while busy")

endmodule

`default_nettype wire

### hdl/f2d_div10.sv
// ----------------------------------------------------------------------------
// f2d_div10
// Divides the rounded coefficient by ten with a reciprocal multiply and
// flags whether the remainder is zero.
// ----------------------------------------------------------------------------
`default_nettype none

module f2d_div10 (
    input  wire logic [f2d_pkg::RND_W-1:0] value,
    output f2d_pkg::div10_t                res
);

    logic [57:0]                   prod;
    logic [f2d_pkg::QUOT_W-1:0]    quot;
    logic [f2d_pkg::RND_W-1:0]     back;

    // Exact for any operand below 2^32.
    assign prod = 58'(value) * 58'(32'hCCCC_CCCD);
    assign quot = prod[57:35];
    assign back = {quot, 3'b000} + {2'b00, quot, 1'b0};

    // Quotient in the upper bits, remainder-is-zero flag in the lowest bit.
    assign res = {quot, (back == value)};

endmodule

`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// float32_to_decimal96 testbench
// Drives binary32 words into the converter and checks every decimal result
// against a table entry or a bit-exact predictor using wide integer scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SCALE  = 28;
    localparam int N_RANDOM   = 880;
    localparam int WATCHDOG   = 4000;
    localparam int QUIET_TAIL = 120;

    typedef struct packed {
        logic [95:0] coeff;
        logic [4:0]  scale;
        logic        negative;
        logic        error;
    } decimal_t;

    typedef struct {
        logic [31:0] bits;
        logic        known;
        decimal_t    result;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         m_tuser;

    decimal_t pending_results[$];
    int       n_errors = 0;
    int       n_sent = 0;
    int       n_got = 0;
    int       idle_cycles = 0;
    bit       stalls_on = 1'b1;
    bit       feeding_done = 1'b0;

    float32_to_decimal96 #(.MAX_SCALE(MAX_SCALE)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Exact conversion: magnitude as a 160-bit integer with sh fraction bits,
    // scaled by ten until its integer part reaches 2^21 or k hits MAX_SCALE.
    function automatic decimal_t convert_float(input logic [31:0] bits);
        decimal_t    d;
        logic [7:0]  bexp;
        logic [23:0] man;
        logic [159:0] n;
        logic [63:0] r, low, half;
        int ex, sh, k, len, dd;
        d = '0;
        bexp = bits[30:23];
        man = {1'b1, bits[22:0]};
        ex = int'(bexp) - 127;
        if (bexp == 8'hFF) begin
            d.error = 1'b1;
            return d;
        end
        if (bits[30:0] == 31'd0 || ex <= -94 || ex >= 96) return d;
        if (ex >= 23) begin
            n = 160'(man) << (ex - 23);
            d.coeff = n[95:0];
            d.negative = bits[31];
            return d;
        end
        sh = 23 - ex;
        k = 0;
        n = 160'(man);
        while (k < MAX_SCALE && (n >> (21 + sh)) == 0) begin
            n = n * 10;
            k++;
        end
        n = n + (160'd1 << (sh - 1));
        r = 64'(n >> sh);
        if (r >= 64'd1 << 24) begin
            len = 0;
            for (int i = 0; i < 64; i++) if (r[i]) len = i + 1;
            dd = len - 24;
            low = r & ((64'd1 << dd) - 1);
            half = 64'd1 << (dd - 1);
            r = r >> dd;
            if (low > half || (low == half && r[0])) r++;
            r = r << dd;
        end
        if (r == 0) return d;
        while (k > 0 && r % 10 == 0) begin
            r = r / 10;
            k--;
        end
        d.coeff = {32'd0, r};
        d.scale = 5'(k);
        d.negative = bits[31];
        return d;
    endfunction

    // Mostly normal values in the converter's range, some of anything.
    function automatic logic [31:0] random_float();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0, 1: ;
            2:       w[30:23] = 8'($urandom_range(34, 36));
            3:       w[30:23] = 8'($urandom_range(220, 224));
            4:       w[30:23] = 8'($urandom_range(140, 160));
            default: w[30:23] = 8'($urandom_range(34, 222));
        endcase
        return w;
    endfunction

    task automatic send_float(input logic [31:0] bits, input decimal_t result);
        if (stalls_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= bits;
        pending_results.push_back(result);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_sent++;
    endtask

    // Result side: random stall bursts, comparison against the oldest entry.
    initial begin
        decimal_t want, got;
        @(posedge aresetn);
        forever begin
            if (stalls_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got = {m_tdata[95:0], m_tdata[100:96], m_tdata[101], m_tuser};
                n_got++;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $realtime, got);
                    n_errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.coeff !== want.coeff) begin
                        $display("%0t: coeff expected %h actual %h",
                                 $realtime, want.coeff, got.coeff);
                        n_errors++;
                    end
                    if (got.scale !== want.scale) begin
                        $display("%0t: scale expected %0d actual %0d",
                                 $realtime, want.scale, got.scale);
                        n_errors++;
                    end
                    if (got.negative !== want.negative) begin
                        $display("%0t: negative expected %b actual %b",
                                 $realtime, want.negative, got.negative);
                        n_errors++;
                    end
                    if (got.error !== want.error) begin
                        $display("%0t: error expected %b actual %b",
                                 $realtime, want.error, got.error);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("watchdog expired with %0d results outstanding",
                     pending_results.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        row_t table_rows[$];
        row_t row;
        decimal_t want;
        table_rows = '{
            '{32'h0000_0000, 1'b1, '0},
            '{32'h8000_0000, 1'b1, '0},
            '{32'h7F80_0000, 1'b1, decimal_t'{96'd0, 5'd0, 1'b0, 1'b1}},
            '{32'hFF80_0000, 1'b1, decimal_t'{96'd0, 5'd0, 1'b0, 1'b1}},
            '{32'h7FC0_0001, 1'b1, decimal_t'{96'd0, 5'd0, 1'b0, 1'b1}},
            '{32'hFFFF_FFFF, 1'b1, decimal_t'{96'd0, 5'd0, 1'b0, 1'b1}},
            '{32'h0000_0001, 1'b1, '0},
            '{32'h807F_FFFF, 1'b1, '0},
            '{32'h1100_0000, 1'b1, decimal_t'{96'd1, 5'd28, 1'b0, 1'b0}},
            '{32'h1180_0000, 1'b0, '0},
            '{32'h11FF_FFFF, 1'b0, '0},
            '{32'h6F80_0000, 1'b1, '0},
            '{32'h6F7F_FFFF, 1'b0, '0},
            '{32'h3F80_0000, 1'b1, decimal_t'{96'd1, 5'd0, 1'b0, 1'b0}},
            '{32'hBF80_0000, 1'b1, decimal_t'{96'd1, 5'd0, 1'b1, 1'b0}},
            '{32'h4B00_0000, 1'b1, decimal_t'{96'd8388608, 5'd0, 1'b0, 1'b0}},
            '{32'h4B7F_FFFF, 1'b0, '0},
            '{32'h4AFF_FFFF, 1'b0, '0},
            '{32'h3DCC_CCCD, 1'b0, '0},
            '{32'h3F00_0000, 1'b1, decimal_t'{96'd5, 5'd1, 1'b0, 1'b0}},
            '{32'h7F7F_FFFF, 1'b0, '0},
            '{32'h3EAA_AAAB, 1'b0, '0},
            '{32'h4049_0FDB, 1'b0, '0},
            '{32'hC2C8_0000, 1'b1, decimal_t'{96'd100, 5'd0, 1'b1, 1'b0}}
        };
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (table_rows[i]) begin
            row = table_rows[i];
            want = row.known ? row.result : convert_float(row.bits);
            if (row.known && want !== convert_float(row.bits))
                $display("table row %0d disagrees with prediction", i);
            send_float(row.bits, want);
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            logic [31:0] w;
            if (i == N_RANDOM - 150) stalls_on = 1'b0;
            w = random_float();
            send_float(w, convert_float(w));
        end
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (QUIET_TAIL) @(posedge aclk);
        $display("converted %0d binary32 words, %0d results checked,", n_sent, n_got);
        $display("covering special values, range edges and random normals");
        if (n_errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
